// ===== rtl/tpag_pkg.sv =====
`timescale 1ns / 1ps

package tpag_pkg;

    // Default sizing of the top level
    localparam int MAX_DIMS_DEF = 4;
    localparam int DIM_BITS_DEF = 16;

    // Fixed field widths
    localparam int FIELD_W   = 16;
    localparam int OFF_W     = 35;
    localparam int RANK_W    = 3;
    localparam int PACKED_W  = 64;
    localparam int PERM_W    = 8;
    localparam int EBYTES_W  = 4;
    localparam int PDATA_W   = 64;
    localparam int PADDR_W   = 6;

    // Saturating element count used for the range check
    localparam int                 PROD_W     = 33;
    localparam logic [PROD_W-1:0]  PROD_ONE   = 33'h0_0000_0001;
    localparam logic [PROD_W-1:0]  PROD_LIMIT = 33'h1_0000_0000;
    localparam logic [PROD_W-1:0]  PROD_SAT   = 33'h1_0000_0001;

    // Register reset values
    localparam logic [RANK_W-1:0]   RANK_RST   = 3'd0;
    localparam logic [PERM_W-1:0]   PERM_RST   = 8'hE4;
    localparam logic [EBYTES_W-1:0] EBYTES_RST = 4'd1;

    // Register map, one 64-bit slot per register
    typedef enum logic [2:0] {
        REG_RANK,
        REG_EXTENTS,
        REG_NOMINAL,
        REG_PERM,
        REG_EBYTES
    } reg_idx_t;

    // Per-request control seen by one counter cell
    typedef struct packed {
        logic accept;
        logic restart;
        logic active;
        logic tail;
    } cell_ctl_t;

    // Weight update command from the weight sequencer to one cell
    typedef struct packed {
        logic             clear;
        logic             src_load;
        logic             dst_add;
        logic [OFF_W-1:0] src_val;
        logic [OFF_W-1:0] dst_val;
    } wt_cmd_t;

endpackage

// ===== rtl/tpag_cell.sv =====
`timescale 1ns / 1ps

module tpag_cell #(
    parameter int DIM_BITS = tpag_pkg::DIM_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tpag_pkg::cell_ctl_t        ctl,
    input  tpag_pkg::wt_cmd_t          wt,
    input  logic [DIM_BITS-1:0]        extent,
    input  logic                       carry_in,
    output logic                       carry_out,
    input  logic [tpag_pkg::OFF_W-1:0] src_sum_in,
    input  logic [tpag_pkg::OFF_W-1:0] dst_sum_in,
    output logic [tpag_pkg::OFF_W-1:0] src_sum_out,
    output logic [tpag_pkg::OFF_W-1:0] dst_sum_out
);

    logic [DIM_BITS-1:0]        cnt_reg;
    logic [DIM_BITS-1:0]        cnt_next;
    logic [tpag_pkg::OFF_W-1:0] src_w_reg;
    logic [tpag_pkg::OFF_W-1:0] src_w_next;
    logic [tpag_pkg::OFF_W-1:0] dst_w_reg;
    logic [tpag_pkg::OFF_W-1:0] dst_w_next;
    logic [tpag_pkg::OFF_W-1:0] src_prod_reg;
    logic [tpag_pkg::OFF_W-1:0] dst_prod_reg;
    logic [DIM_BITS-1:0]        cur;
    logic [DIM_BITS:0]          inc;
    logic                       wrap;
    logic                       cin;

    // Coordinate for this request and its odometer step
    assign cur       = ctl.restart ? '0 : cnt_reg;
    assign inc       = {1'b0, cur} + {{DIM_BITS{1'b0}}, 1'b1};
    assign wrap      = inc >= {1'b0, extent};
    assign cin       = ctl.active && (ctl.tail || carry_in);
    assign carry_out = cin && wrap;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.accept)
        begin
            if (cin)
            begin
                cnt_next = wrap ? '0 : inc[DIM_BITS-1:0];
            end
            else
            begin
                cnt_next = cur;
            end
        end
    end

    // Rebuild stride weights on command from the sequencer
    always_comb
    begin
        src_w_next = src_w_reg;
        dst_w_next = dst_w_reg;
        if (wt.clear)
        begin
            src_w_next = '0;
            dst_w_next = '0;
        end
        else
        begin
            if (wt.src_load)
            begin
                src_w_next = wt.src_val;
            end
            if (wt.dst_add)
            begin
                dst_w_next = dst_w_reg + wt.dst_val;
            end
        end
    end

    // Hold the coordinate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Weights and per-request partial products
    always_ff @(posedge clk)
    begin
        src_w_reg <= src_w_next;
        dst_w_reg <= dst_w_next;
        if (ctl.accept)
        begin
            src_prod_reg <= tpag_pkg::OFF_W'(cur) * src_w_reg;
            dst_prod_reg <= tpag_pkg::OFF_W'(cur) * dst_w_reg;
        end
    end

    // Add this cell's share to the running offsets
    assign src_sum_out = src_sum_in + src_prod_reg;
    assign dst_sum_out = dst_sum_in + dst_prod_reg;

endmodule

// ===== rtl/tpag_wseq.sv =====
`timescale 1ns / 1ps

module tpag_wseq #(
    parameter int MAX_DIMS = tpag_pkg::MAX_DIMS_DEF,
    parameter int DIM_BITS = tpag_pkg::DIM_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tpag_pkg::RANK_W-1:0]   n,
    input  logic [tpag_pkg::PACKED_W-1:0] nominal,
    input  logic [tpag_pkg::PERM_W-1:0]   perm,
    input  logic [tpag_pkg::EBYTES_W-1:0] elem_bytes,
    output logic                          busy,
    output logic                          range_error,
    output tpag_pkg::wt_cmd_t             wt_cmd [MAX_DIMS]
);

    localparam int KW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int PFW = tpag_pkg::PROD_W + DIM_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_RUN
    } state_t;

    state_t                       state_reg;
    logic [KW-1:0]                k_reg;
    logic [tpag_pkg::OFF_W-1:0]   sacc_reg;
    logic [tpag_pkg::OFF_W-1:0]   dacc_reg;
    logic [tpag_pkg::PROD_W-1:0]  prod_reg;
    logic [1:0]                   k2;
    logic [1:0]                   pe;
    logic [DIM_BITS-1:0]          sdim;
    logic [DIM_BITS-1:0]          pdim;
    logic                         k_live;
    logic                         pe_live;
    logic [tpag_pkg::OFF_W-1:0]   sacc_mul;
    logic [tpag_pkg::OFF_W-1:0]   dacc_mul;
    logic [PFW-1:0]               pfull;
    logic [tpag_pkg::PROD_W-1:0]  psat;

    // Select the dimension handled in this step
    assign k2      = 2'(k_reg);
    assign pe      = perm[{k2, 1'b0} +: 2];
    assign sdim    = nominal[{k2, 4'b0000} +: DIM_BITS];
    assign pdim    = nominal[{pe, 4'b0000} +: DIM_BITS];
    assign k_live  = tpag_pkg::RANK_W'(k_reg) < n;
    assign pe_live = {1'b0, pe} < n;

    // Running strides (pre-scaled by element size) and saturating count
    assign sacc_mul = sacc_reg * tpag_pkg::OFF_W'(sdim);
    assign dacc_mul = dacc_reg * tpag_pkg::OFF_W'(pdim);
    assign pfull    = PFW'(prod_reg) * PFW'(sdim);
    assign psat     = (pfull > PFW'(tpag_pkg::PROD_LIMIT)) ? tpag_pkg::PROD_SAT
                                                           : pfull[tpag_pkg::PROD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            k_reg     <= '0;
            sacc_reg  <= '0;
            dacc_reg  <= '0;
            prod_reg  <= tpag_pkg::PROD_ONE;
        end
        else if (start)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    state_reg <= S_IDLE;
                end
                S_INIT:
                begin
                    sacc_reg  <= tpag_pkg::OFF_W'(elem_bytes);
                    dacc_reg  <= tpag_pkg::OFF_W'(elem_bytes);
                    prod_reg  <= tpag_pkg::PROD_ONE;
                    k_reg     <= KW'(MAX_DIMS - 1);
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (k_live)
                    begin
                        sacc_reg <= sacc_mul;
                        dacc_reg <= dacc_mul;
                        prod_reg <= psat;
                    end
                    if (k_reg == '0)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg <= k_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Drive weight commands to the cells
    always_comb
    begin
        for (int j = 0; j < MAX_DIMS; j++)
        begin
            wt_cmd[j].clear    = (state_reg == S_INIT);
            wt_cmd[j].src_load = (state_reg == S_RUN) && k_live && (k_reg == KW'(j));
            wt_cmd[j].dst_add  = (state_reg == S_RUN) && k_live && pe_live && (pe == 2'(j));
            wt_cmd[j].src_val  = sacc_reg;
            wt_cmd[j].dst_val  = dacc_reg;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign range_error = prod_reg > tpag_pkg::PROD_LIMIT;

endmodule

// ===== rtl/tensor_permute_address_gen.sv =====
`timescale 1ns / 1ps
// Channel   Signals                                              Direction
// request   req_valid, req_ready, restart                        in
// result    res_valid, res_ready, src_offset, dst_offset,         out
//           last, range_error
// config    psel, penable, pwrite, paddr, pwdata, prdata, pready  APB slave
//
// One request per cycle while results drain and no weight rebuild is running;
// each result passes through the product stage and the output register.
// The rate is set by the row of counter cells, which step the odometer and form
// the partial products for one coordinate each. After reset and after every
// register write, req_ready stays low while the weight sequencer rebuilds the
// stride weights. A stalled result holds in the output register; one more
// request may sit in the product stage behind it before req_ready drops.

module tensor_permute_address_gen #(
    parameter int MAX_DIMS = tpag_pkg::MAX_DIMS_DEF,
    parameter int DIM_BITS = tpag_pkg::DIM_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          restart,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [tpag_pkg::OFF_W-1:0]    src_offset,
    output logic [tpag_pkg::OFF_W-1:0]    dst_offset,
    output logic                          last,
    output logic                          range_error,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpag_pkg::PADDR_W-1:0]  paddr,
    input  logic [tpag_pkg::PDATA_W-1:0]  pwdata,
    output logic [tpag_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam logic [tpag_pkg::RANK_W-1:0] MAXD = tpag_pkg::RANK_W'(MAX_DIMS);

    logic [tpag_pkg::RANK_W-1:0]   rank_reg;
    logic [tpag_pkg::PACKED_W-1:0] extents_reg;
    logic [tpag_pkg::PACKED_W-1:0] nominal_reg;
    logic [tpag_pkg::PERM_W-1:0]   perm_reg;
    logic [tpag_pkg::EBYTES_W-1:0] ebytes_reg;
    logic                          cfg_write;
    tpag_pkg::reg_idx_t            cfg_idx;
    logic [tpag_pkg::RANK_W-1:0]   n;

    logic                          seq_busy;
    logic                          seq_range_error;
    tpag_pkg::wt_cmd_t             wt_cmd [MAX_DIMS];

    logic                          accept;
    logic                          out_adv;
    logic                          s1_adv;
    logic                          last_now;
    logic                          s1_valid_reg;
    logic                          s1_last_reg;
    logic                          s1_rerr_reg;
    logic                          res_valid_reg;
    logic [tpag_pkg::OFF_W-1:0]    src_offset_reg;
    logic [tpag_pkg::OFF_W-1:0]    dst_offset_reg;
    logic                          last_reg;
    logic                          rerr_reg;

    logic                          carry     [MAX_DIMS+1];
    logic [tpag_pkg::OFF_W-1:0]    src_chain [MAX_DIMS+1];
    logic [tpag_pkg::OFF_W-1:0]    dst_chain [MAX_DIMS+1];

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = tpag_pkg::reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg    <= tpag_pkg::RANK_RST;
            extents_reg <= '0;
            nominal_reg <= '0;
            perm_reg    <= tpag_pkg::PERM_RST;
            ebytes_reg  <= tpag_pkg::EBYTES_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                tpag_pkg::REG_RANK:    rank_reg    <= pwdata[tpag_pkg::RANK_W-1:0];
                tpag_pkg::REG_EXTENTS: extents_reg <= pwdata;
                tpag_pkg::REG_NOMINAL: nominal_reg <= pwdata;
                tpag_pkg::REG_PERM:    perm_reg    <= pwdata[tpag_pkg::PERM_W-1:0];
                tpag_pkg::REG_EBYTES:  ebytes_reg  <= pwdata[tpag_pkg::EBYTES_W-1:0];
                default:               rank_reg    <= rank_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            tpag_pkg::REG_RANK:    prdata = tpag_pkg::PDATA_W'(rank_reg);
            tpag_pkg::REG_EXTENTS: prdata = extents_reg;
            tpag_pkg::REG_NOMINAL: prdata = nominal_reg;
            tpag_pkg::REG_PERM:    prdata = tpag_pkg::PDATA_W'(perm_reg);
            tpag_pkg::REG_EBYTES:  prdata = tpag_pkg::PDATA_W'(ebytes_reg);
            default:               prdata = '0;
        endcase
    end

    // Clamp the rank to the number of cells
    assign n = (rank_reg > MAXD) ? MAXD : rank_reg;

    // Stride weights
    tpag_wseq #(
        .MAX_DIMS (MAX_DIMS),
        .DIM_BITS (DIM_BITS)
    ) u_wseq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cfg_write),
        .n           (n),
        .nominal     (nominal_reg),
        .perm        (perm_reg),
        .elem_bytes  (ebytes_reg),
        .busy        (seq_busy),
        .range_error (seq_range_error),
        .wt_cmd      (wt_cmd)
    );

    // Pipeline flow: product stage, then output register
    assign out_adv   = !res_valid_reg || res_ready;
    assign s1_adv    = !s1_valid_reg || out_adv;
    assign req_ready = s1_adv && !seq_busy;
    assign accept    = req_valid && req_ready;

    // Chain of counter cells; carry and partial sums run from the last dimension down
    assign carry[MAX_DIMS]     = 1'b0;
    assign src_chain[MAX_DIMS] = '0;
    assign dst_chain[MAX_DIMS] = '0;

    for (genvar j = 0; j < MAX_DIMS; j++)
    begin : g_cell
        tpag_pkg::cell_ctl_t ctl;

        assign ctl.accept  = accept;
        assign ctl.restart = restart;
        assign ctl.active  = tpag_pkg::RANK_W'(j) < n;
        assign ctl.tail    = tpag_pkg::RANK_W'(j) == (n - 3'd1);

        tpag_cell #(
            .DIM_BITS (DIM_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .wt          (wt_cmd[j]),
            .extent      (extents_reg[j*tpag_pkg::FIELD_W +: DIM_BITS]),
            .carry_in    (carry[j+1]),
            .carry_out   (carry[j]),
            .src_sum_in  (src_chain[j+1]),
            .dst_sum_in  (dst_chain[j+1]),
            .src_sum_out (src_chain[j]),
            .dst_sum_out (dst_chain[j])
        );
    end

    // Final element when the carry leaves the first dimension, or rank zero
    assign last_now = (n == 3'd0) || carry[0];

    // Product stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= last_now;
            s1_rerr_reg <= seq_range_error;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            src_offset_reg <= src_chain[0];
            dst_offset_reg <= dst_chain[0];
            last_reg       <= s1_last_reg;
            rerr_reg       <= s1_rerr_reg;
        end
    end

    assign res_valid   = res_valid_reg;
    assign src_offset  = src_offset_reg;
    assign dst_offset  = dst_offset_reg;
    assign last        = last_reg;
    assign range_error = rerr_reg;

`ifndef NO_ASSERTIONS
    // A register write blocks requests while the weights rebuild
    a_write_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !req_ready)
        else $error("request port open right after a register write");

    // Rank zero makes every element the final one
    a_rank_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (n == 3'd0)) |=> s1_last_reg)
        else $error("rank zero element not flagged last");

    // A blocked product stage keeps its request
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_adv) |=> (s1_valid_reg && $stable(s1_last_reg)))
        else $error("product stage lost a request under stall");

    // Both stages full and stalled: no new request
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready && s1_valid_reg) |-> !req_ready)
        else $error("request taken with the pipeline full");
`endif

endmodule
